// File: hdl/csemq_pkg.sv
package csemq_pkg;

	// default sizes of the wait queue and of a task id
	localparam int MAX_WAITERS_DEF  = 16;
	localparam int TASK_ID_BITS_DEF = 6;

	// signed semaphore count
	localparam int CNT_W  = 17;
	localparam int OUT_CNT_W = 16;
	localparam int INIT_W = 15;

	localparam logic signed [CNT_W-1:0] CNT_ZERO = '0;
	localparam logic signed [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic signed [CNT_W-1:0] CNT_MAX  = CNT_W'(32767);

	// operation codes
	localparam logic [1:0] FN_WAIT   = 2'd0;
	localparam logic [1:0] FN_SIGNAL = 2'd1;
	localparam logic [1:0] FN_CANCEL = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_QUEUED   = 3'd1;
	localparam logic [2:0] ST_TIMEOUT  = 3'd2;
	localparam logic [2:0] ST_ACCESS   = 3'd3;
	localparam logic [2:0] ST_RESOURCE = 3'd4;
	localparam logic [2:0] ST_VALUE    = 3'd5;
	localparam logic [2:0] ST_OVERFLOW = 3'd6;

	// configuration register indexes
	localparam logic CFG_INIT_COUNT = 1'b0;
	localparam logic CFG_BINARY     = 1'b1;

	// queue commands broadcast to every cell
	typedef struct packed {
		logic shift;   // whole queue moves one place toward the head
		logic load;    // tail cell takes the key
	} csemq_ctl_t;

	// cancel search token handed from cell to cell
	typedef struct packed {
		logic tok;
		logic found;
	} csemq_scan_t;

endpackage

// File: hdl/csemq_cell.sv
module csemq_cell
	import csemq_pkg::*;
#(
	parameter int ID_W = TASK_ID_BITS_DEF,
	parameter int TOT_W = 5,
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  csemq_ctl_t        ctl,
	input  logic [TOT_W-1:0]  total,
	input  logic [ID_W-1:0]   key,
	input  logic [ID_W-1:0]   next_id,
	input  csemq_scan_t       scan_in,
	output csemq_scan_t       scan_out,
	output logic [ID_W-1:0]   id_out
);

	logic [ID_W-1:0] id_q;
	csemq_scan_t     scan_q;
	logic            in_queue;
	logic            hit;
	logic            pull;
	logic            load_here;

	assign in_queue  = TOT_W'(IDX) < total;
	assign load_here = ctl.load && (TOT_W'(IDX) == total);
	assign hit       = scan_in.tok && in_queue && (id_q == key);
	// once the search has matched, every later cell closes the gap
	assign pull      = ctl.shift || (scan_in.tok && (scan_in.found || hit));

	always_ff @(posedge clk) begin
		if (load_here) begin
			id_q <= key;
		end else if (pull) begin
			id_q <= next_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q.tok   <= scan_in.tok;
			scan_q.found <= scan_in.found || hit;
		end
	end

	assign scan_out = scan_q;
	assign id_out   = id_q;

endmodule

// File: hdl/counting_semaphore_wait_queue_top.sv
// channel | direction | handshake              | beat contents
// in      | input     | in_valid / in_ready    | func, task_id, no_wait, caller_extended,
//         |           |                        | caller_holds_resources
// out     | output    | out_valid / out_ready  | status, woken_valid, woken_task, count_now
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// wait, signal and bad codes: the item passes S_EXEC and S_DONE, then its result enters the output register
// cancel: the item passes S_EXEC, then S_SCAN while the search runs, then S_DONE;
// the search token walks the cell row, one cell per cycle, closing the gap behind the first match
// one item at a time; a new beat is taken while the last result waits on out_ready,
// and while out_ready is low on a waiting result the next result is held back in S_DONE
// reset: count 0, queue empty, binary mode off; cfg_ready is always high
module counting_semaphore_wait_queue_top
	import csemq_pkg::*;
#(
	parameter int MAX_WAITERS  = MAX_WAITERS_DEF,
	parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    func,
	input  logic [TASK_ID_BITS-1:0]       task_id,
	input  logic                          no_wait,
	input  logic                          caller_extended,
	input  logic                          caller_holds_resources,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic                          woken_valid,
	output logic [TASK_ID_BITS-1:0]       woken_task,
	output logic signed [OUT_CNT_W-1:0]   count_now,
	// configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [INIT_W-1:0]             cfg_data
);

	localparam int TOT_W = $clog2(MAX_WAITERS + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                    state_q;
	// latched item
	logic [1:0]                func_q;
	logic [TASK_ID_BITS-1:0]   key_q;
	logic                      no_wait_q;
	logic                      ext_q;
	logic                      holds_q;
	// semaphore state
	logic signed [CNT_W-1:0]   cnt_q;
	logic [TOT_W-1:0]          total_q;
	logic                      binary_q;
	// finished result, waiting for the output register
	logic [2:0]                res_status_q;
	logic                      res_wv_q;
	logic [TASK_ID_BITS-1:0]   res_wt_q;
	logic [OUT_CNT_W-1:0]      res_cnt_q;
	// output register
	logic                      out_valid_q;
	logic [2:0]                status_q;
	logic                      woken_valid_q;
	logic [TASK_ID_BITS-1:0]   woken_task_q;
	logic [OUT_CNT_W-1:0]      count_now_q;

	// decision of the execute cycle
	logic [2:0]                ex_status;
	logic signed [CNT_W-1:0]   ex_cnt;
	logic [TOT_W-1:0]          ex_total;
	logic                      ex_wv;
	logic [TASK_ID_BITS-1:0]   ex_wt;
	logic                      scan_go;
	csemq_ctl_t                ctl;

	// end of the cancel search
	logic signed [CNT_W-1:0]   sc_cnt;
	logic                      scan_done;
	logic                      out_free;

	logic [TASK_ID_BITS-1:0]   id_c   [MAX_WAITERS];
	csemq_scan_t               scan_c [MAX_WAITERS+1];

	logic signed [CNT_W-1:0]   total_ext;

	// ------------------------------------------------------------------
	// row of queue cells, cell 0 is the head
	// ------------------------------------------------------------------
	assign scan_c[0].tok   = scan_go;
	assign scan_c[0].found = 1'b0;

	for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
		logic [TASK_ID_BITS-1:0] nxt;
		if (i == MAX_WAITERS - 1) begin : g_last
			assign nxt = id_c[i];       // shifted-in value past the tail is never read
		end else begin : g_mid
			assign nxt = id_c[i+1];
		end
		csemq_cell #(
			.ID_W  (TASK_ID_BITS),
			.TOT_W (TOT_W),
			.IDX   (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.total    (total_q),
			.key      (key_q),
			.next_id  (nxt),
			.scan_in  (scan_c[i]),
			.scan_out (scan_c[i+1]),
			.id_out   (id_c[i])
		);
	end

	// ------------------------------------------------------------------
	// execute cycle: wait, signal and bad codes finish here; cancel
	// launches the search token into cell 0
	// ------------------------------------------------------------------
	always_comb begin
		ex_status = ST_VALUE;
		ex_cnt    = cnt_q;
		ex_total  = total_q;
		ex_wv     = 1'b0;
		ex_wt     = '0;
		scan_go   = 1'b0;
		ctl       = '0;
		if (state_q == S_EXEC) begin
			case (func_q)
				FN_WAIT: begin
					if (!ext_q) begin
						ex_status = ST_ACCESS;
					end else if (holds_q) begin
						ex_status = ST_RESOURCE;
					end else if (cnt_q > CNT_ZERO) begin
						ex_cnt    = cnt_q - CNT_ONE;
						ex_status = ST_OK;
					end else if (no_wait_q) begin
						ex_status = ST_TIMEOUT;
					end else if (total_q >= TOT_W'(MAX_WAITERS)) begin
						ex_status = ST_OVERFLOW;
					end else begin
						// join the tail
						ctl.load  = 1'b1;
						ex_total  = total_q + TOT_W'(1);
						ex_cnt    = cnt_q - CNT_ONE;
						ex_status = ST_QUEUED;
					end
				end
				FN_SIGNAL: begin
					if (binary_q && cnt_q == CNT_ONE) begin
						ex_status = ST_VALUE;
					end else if (cnt_q >= CNT_MAX) begin
						ex_status = ST_OVERFLOW;
					end else begin
						ex_cnt    = cnt_q + CNT_ONE;
						ex_status = ST_OK;
						// release the head waiter while units are still owed
						if (ex_cnt <= CNT_ZERO && total_q != '0) begin
							ex_wv     = 1'b1;
							ex_wt     = id_c[0];
							ctl.shift = 1'b1;
							ex_total  = total_q - TOT_W'(1);
						end
					end
				end
				FN_CANCEL: begin
					scan_go = 1'b1;
				end
				default: begin
					ex_status = ST_VALUE;
				end
			endcase
		end
	end

	// the search is done when the token reaches the registered output of the last cell
	assign scan_done = (state_q == S_SCAN) && scan_c[MAX_WAITERS].tok;
	assign sc_cnt    = (cnt_q < CNT_MAX) ? (cnt_q + CNT_ONE) : cnt_q;
	assign out_free  = !out_valid_q || out_ready;

	// ------------------------------------------------------------------
	// control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= CNT_ZERO;
			total_q     <= '0;
			binary_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a finished result refills the output register once it is empty or as the old beat leaves
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (scan_go) begin
						state_q <= S_SCAN;
					end else begin
						cnt_q   <= ex_cnt;
						total_q <= ex_total;
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						if (scan_c[MAX_WAITERS].found) begin
							cnt_q   <= sc_cnt;
							total_q <= total_q - TOT_W'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// user sends configuration beats only while idle; not enforced by the block
			if (cfg_valid) begin
				case (cfg_index)
					CFG_INIT_COUNT: begin
						cnt_q   <= signed'(CNT_W'(cfg_data));
						total_q <= '0;
					end
					CFG_BINARY: begin
						binary_q <= cfg_data[0];
					end
					default: begin
						binary_q <= binary_q;
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			func_q    <= func;
			key_q     <= task_id;
			no_wait_q <= no_wait;
			ext_q     <= caller_extended;
			holds_q   <= caller_holds_resources;
		end
		if (state_q == S_EXEC && !scan_go) begin
			res_status_q <= ex_status;
			res_wv_q     <= ex_wv;
			res_wt_q     <= ex_wt;
			res_cnt_q    <= ex_cnt[OUT_CNT_W-1:0];
		end
		if (scan_done) begin
			res_wv_q <= 1'b0;
			res_wt_q <= '0;
			if (scan_c[MAX_WAITERS].found) begin
				res_status_q <= ST_TIMEOUT;
				res_cnt_q    <= sc_cnt[OUT_CNT_W-1:0];
			end else begin
				res_status_q <= ST_VALUE;
				res_cnt_q    <= cnt_q[OUT_CNT_W-1:0];
			end
		end
		if (state_q == S_DONE && out_free) begin
			status_q      <= res_status_q;
			woken_valid_q <= res_wv_q;
			woken_task_q  <= res_wt_q;
			count_now_q   <= res_cnt_q;
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign woken_valid = woken_valid_q;
	assign woken_task  = woken_task_q;
	assign count_now   = signed'(count_now_q);

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	assign total_ext = signed'(CNT_W'(total_q));

	// every queued waiter is owed exactly one unit
	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[CNT_W-1] || total_q != '0) |-> (cnt_q + total_ext == CNT_ZERO))
		else $error("count and waiter total disagree");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOT_W'(MAX_WAITERS))
		else $error("waiter total beyond queue size");

	a_token: assert property (@(posedge clk) disable iff (!arst_n)
		scan_c[MAX_WAITERS].tok |-> (state_q == S_SCAN))
		else $error("search token outside a cancel");

	a_woken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((woken_valid_q && status_q == ST_OK) ||
			(!woken_valid_q && woken_task_q == '0)))
		else $error("woken fields inconsistent with status");

endmodule
